// ===== rtl/bsd_pkg.sv =====
// Package for the BSD scheduler statistics engine.
// Holds widths, defaults, command codes, state machine type and fixed-point helpers.
`default_nettype none
package bsd_pkg;
	localparam int MAX_THREADS_DEF = 64;
	localparam int PRIORITY_TOP_DEF = 63;
	localparam int FRACTION_BITS_DEF = 14;
	localparam int TPS_RESET = 100;
	localparam int SLICE_RESET = 4;
	localparam int NICE_LOW = -20;
	localparam int NICE_HIGH = 20;

	typedef enum logic [2:0] {
		CMD_TICK = 3'd0,
		CMD_SET_NICE = 3'd1,
		CMD_RECOMPUTE = 3'd2,
		CMD_CREATE = 3'd3,
		CMD_EXIT = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_ENABLE = 2'd0,
		CFG_TPS = 2'd1,
		CFG_SLICE = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_LA_MUL,
		ST_LA_ADD,
		ST_DIV,
		ST_SWEEP_RD,
		ST_SWEEP_WAIT,
		ST_SWEEP_MUL,
		ST_SWEEP_WR,
		ST_OUT_RD,
		ST_OUT_WAIT,
		ST_OUT_MUL,
		ST_OUT_RND,
		ST_OUT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/bsd_mlfq_scheduler_stats.sv =====
// BSD 4.4 style scheduler statistics engine: top level, the only module.
// Depends on bsd_pkg for codes, state type and helpers.
//
// Usage: an input word (cmd and operands) is accepted when in_valid is high
// and in_stall is low. The block works on one word at a time; in_stall is
// high while it is busy. One result word per input word appears on out_valid
// and holds until out_stall is low. While a result waits, the block takes no
// new word, so a stalled receiver stalls the sender.
// Per-thread state lives in one synchronous table memory with a registered
// read port; a valid bit per slot is kept in flip-flops so that reset
// clears the table at once (an invalid slot reads as zero).
// Order of work: a simple command or tick passes the read, execute, output
// read, wait, multiply and rounding states before its result shows. When
// enabled, a recompute sweeps all MAX_THREADS slots, each through read, wait,
// multiply and write states; a second-boundary tick adds a load average
// multiply-add, a bit-serial decay coefficient divide and a recent cpu sweep.
// User must write configuration on cfg_we while no word is in flight; unchecked.
// Reset: all slots invalid, load average and counters zero, registers at
// their defaults (enable on, 100 ticks per second, slice of 4).
`default_nettype none
module bsd_mlfq_scheduler_stats #(
	parameter int MAX_THREADS = bsd_pkg::MAX_THREADS_DEF,
	parameter int PRIORITY_TOP = bsd_pkg::PRIORITY_TOP_DEF,
	parameter int FRACTION_BITS = bsd_pkg::FRACTION_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [9:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] cmd,
	input wire logic [5:0] thread_id,
	input wire logic signed [5:0] nice_value,
	input wire logic [5:0] initial_priority,
	input wire logic running_is_idle,
	input wire logic [6:0] ready_threads,
	output logic out_valid,
	input wire logic out_stall,
	output logic [5:0] thread_priority,
	output logic [12:0] load_avg_x100,
	output logic signed [31:0] recent_cpu_x100,
	output logic yield_request
);
	localparam int AW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int CW = AW + 1;
	localparam longint ONE = 64'sd1 <<< FRACTION_BITS;
	localparam longint C59 = (59 * ONE) / 60;
	localparam longint C1 = ONE / 60;
	localparam int DIVN = 32 + FRACTION_BITS + 2;
	localparam int DCW = $clog2(DIVN + 2);

	// memory entry: recent cpu, nice, priority
	localparam int EW = 32 + 6 + 8;
	logic [EW-1:0] mem [MAX_THREADS];
	logic [MAX_THREADS-1:0] valid_q;
	logic mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [EW-1:0] mem_wd, mem_rd_s1;
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd_s1 <= mem[mem_ra];
	end

	bsd_pkg::state_t state_q, state_d;
	logic en_q;
	logic [9:0] tps_q;
	logic [7:0] slice_q;
	logic [9:0] sec_q;
	logic [7:0] scnt_q;
	logic signed [31:0] la_q;
	logic [2:0] cmd_q;
	logic [5:0] tid_q, ipri_q;
	logic signed [5:0] nice_q;
	logic idle_q;
	logic [6:0] ready_q;
	logic yield_q;
	logic [CW-1:0] idx_q;
	logic sweep_decay_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] coeff_q;
	// divider
	logic [63:0] dnum_q, drem_q;
	logic [32:0] dden_q;
	logic [DCW-1:0] dcnt_q;
	// output regs
	logic [5:0] opri_q;
	logic signed [31:0] orc_q;
	logic [12:0] ola_q;
	logic signed [63:0] rc100_q, la100_q;

	logic in_range_q;
	assign in_range_q = ({{(32-6){1'b0}}, tid_q} < 32'(MAX_THREADS));
	logic [AW-1:0] tid_a;
	assign tid_a = AW'(tid_q);
	logic [AW-1:0] idx_a;
	assign idx_a = idx_q[AW-1:0];

	logic signed [31:0] rd_rc;
	logic signed [5:0] rd_nice;
	logic [7:0] rd_pri;
	assign rd_rc = mem_rd_s1[EW-1 -: 32];
	assign rd_nice = mem_rd_s1[13:8];
	assign rd_pri = mem_rd_s1[7:0];

	function automatic logic [7:0] calc_pri(input logic signed [31:0] rc,
			input logic signed [5:0] nv);
		logic signed [63:0] v, p;
		v = 64'(PRIORITY_TOP) * ONE - 64'(rc) / 4 - 64'(nv) * 2 * ONE;
		p = v >>> FRACTION_BITS;
		if (v < 0 && (v & (ONE - 1)) != 0) p = p + 1;
		if (p < 0) p = 0;
		if (p > PRIORITY_TOP) p = PRIORITY_TOP;
		return p[7:0];
	endfunction

	// truncating shift toward zero
	function automatic logic signed [63:0] tdiv(input logic signed [63:0] x);
		logic signed [63:0] r;
		r = x >>> FRACTION_BITS;
		if (x < 0 && (x & (ONE - 1)) != 0) r = r + 1;
		return r;
	endfunction

	function automatic logic signed [63:0] rdiv(input logic signed [63:0] x);
		if (x >= 0) return (x + ONE / 2) >>> FRACTION_BITS;
		return -((-x + ONE / 2) >>> FRACTION_BITS);
	endfunction

	logic [9:0] tps_eff;
	logic [7:0] ts_eff;
	assign tps_eff = (tps_q == 10'd0) ? 10'd1 : tps_q;
	assign ts_eff = (slice_q == 8'd0) ? 8'd1 : slice_q;
	logic signed [6:0] nice_in;
	assign nice_in = (7'(nice_value) < 7'(bsd_pkg::NICE_LOW)) ? 7'(bsd_pkg::NICE_LOW) :
		(7'(nice_value) > 7'(bsd_pkg::NICE_HIGH)) ? 7'(bsd_pkg::NICE_HIGH) :
		7'(nice_value);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bsd_pkg::ST_IDLE: if (in_valid) state_d = bsd_pkg::ST_READ;
			bsd_pkg::ST_READ: state_d = bsd_pkg::ST_EXEC;
			bsd_pkg::ST_EXEC: begin
				state_d = bsd_pkg::ST_OUT_RD;
				if (cmd_q == bsd_pkg::CMD_TICK && en_q &&
						(32'(sec_q) + 1 >= 32'(tps_eff)))
					state_d = bsd_pkg::ST_LA_MUL;
				else if (cmd_q == bsd_pkg::CMD_RECOMPUTE && en_q)
					state_d = bsd_pkg::ST_SWEEP_RD;
			end
			bsd_pkg::ST_LA_MUL: state_d = bsd_pkg::ST_LA_ADD;
			bsd_pkg::ST_LA_ADD: state_d = bsd_pkg::ST_DIV;
			bsd_pkg::ST_DIV: if (dcnt_q == '0) state_d = bsd_pkg::ST_SWEEP_RD;
			bsd_pkg::ST_SWEEP_RD: state_d = bsd_pkg::ST_SWEEP_WAIT;
			bsd_pkg::ST_SWEEP_WAIT: state_d = bsd_pkg::ST_SWEEP_MUL;
			bsd_pkg::ST_SWEEP_MUL: state_d = bsd_pkg::ST_SWEEP_WR;
			bsd_pkg::ST_SWEEP_WR:
				state_d = (idx_q == CW'(MAX_THREADS - 1)) ? bsd_pkg::ST_OUT_RD :
					bsd_pkg::ST_SWEEP_RD;
			bsd_pkg::ST_OUT_RD: state_d = bsd_pkg::ST_OUT_WAIT;
			bsd_pkg::ST_OUT_WAIT: state_d = bsd_pkg::ST_OUT_MUL;
			bsd_pkg::ST_OUT_MUL: state_d = bsd_pkg::ST_OUT_RND;
			bsd_pkg::ST_OUT_RND: state_d = bsd_pkg::ST_OUT;
			bsd_pkg::ST_OUT: if (!out_stall) state_d = bsd_pkg::ST_IDLE;
			default: state_d = bsd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != bsd_pkg::ST_IDLE);
		out_valid = (state_q == bsd_pkg::ST_OUT);
		thread_priority = opri_q;
		load_avg_x100 = ola_q;
		recent_cpu_x100 = orc_q;
		yield_request = yield_q;
	end

	// memory port control
	logic valid_cur;
	assign valid_cur = in_range_q && valid_q[tid_a];
	always_comb begin
		mem_we = 1'b0;
		mem_wa = tid_a;
		mem_wd = mem_rd_s1;
		mem_ra = tid_a;
		case (state_q)
			bsd_pkg::ST_EXEC: begin
				case (cmd_q)
					bsd_pkg::CMD_TICK: begin
						mem_we = en_q && !idle_q && valid_cur;
						mem_wd = {bsd_pkg::sat32(66'(rd_rc) + 66'(ONE)), rd_nice, rd_pri};
					end
					bsd_pkg::CMD_SET_NICE: begin
						mem_we = valid_cur;
						mem_wd = {rd_rc, nice_q,
							en_q ? calc_pri(rd_rc, nice_q) : rd_pri};
					end
					bsd_pkg::CMD_CREATE: begin
						mem_we = in_range_q;
						mem_wd = {32'sd0, 6'sd0, (32'(ipri_q) > 32'(PRIORITY_TOP)) ?
							8'(PRIORITY_TOP) : 8'(ipri_q)};
					end
					bsd_pkg::CMD_EXIT: begin
						mem_we = in_range_q;
						mem_wd = '0;
					end
					default: mem_we = 1'b0;
				endcase
			end
			// The read address stays on the swept slot so that its data
			// remains on the read port until the write-back.
			bsd_pkg::ST_SWEEP_RD, bsd_pkg::ST_SWEEP_WAIT, bsd_pkg::ST_SWEEP_MUL:
				mem_ra = idx_a;
			bsd_pkg::ST_SWEEP_WR: begin
				mem_ra = idx_a;
				mem_wa = idx_a;
				mem_we = valid_q[idx_a];
				if (sweep_decay_q)
					mem_wd = {bsd_pkg::sat32(66'(tdiv(prod_q)) +
						66'(64'(rd_nice) * ONE)), rd_nice, rd_pri};
				else
					mem_wd = {rd_rc, rd_nice, calc_pri(rd_rc, rd_nice)};
			end
			default: mem_ra = tid_a;
		endcase
	end

	logic signed [31:0] rc_out;
	logic [5:0] pri_out;
	assign rc_out = valid_cur ? rd_rc : 32'sd0;
	assign pri_out = valid_cur ? rd_pri[5:0] : 6'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsd_pkg::ST_IDLE;
			en_q <= 1'b1;
			tps_q <= 10'(bsd_pkg::TPS_RESET);
			slice_q <= 8'(bsd_pkg::SLICE_RESET);
			sec_q <= '0;
			scnt_q <= '0;
			la_q <= '0;
			valid_q <= '0;
			yield_q <= 1'b0;
			idx_q <= '0;
			sweep_decay_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					bsd_pkg::CFG_ENABLE: en_q <= cfg_data[0];
					bsd_pkg::CFG_TPS: tps_q <= cfg_data;
					bsd_pkg::CFG_SLICE: slice_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			case (state_q)
				bsd_pkg::ST_IDLE: if (in_valid) yield_q <= 1'b0;
				bsd_pkg::ST_EXEC: begin
					idx_q <= '0;
					sweep_decay_q <= (cmd_q == bsd_pkg::CMD_TICK);
					if (cmd_q == bsd_pkg::CMD_TICK) begin
						sec_q <= (32'(sec_q) + 1 >= 32'(tps_eff)) ? 10'd0 : sec_q + 10'd1;
						if (32'(scnt_q) + 1 >= 32'(ts_eff)) begin
							scnt_q <= '0;
							yield_q <= 1'b1;
						end else scnt_q <= scnt_q + 8'd1;
					end
					if (cmd_q == bsd_pkg::CMD_CREATE && in_range_q) valid_q[tid_a] <= 1'b1;
					if (cmd_q == bsd_pkg::CMD_EXIT && in_range_q) valid_q[tid_a] <= 1'b0;
				end
				bsd_pkg::ST_LA_ADD: begin
					la_q <= bsd_pkg::sat32(66'(tdiv(prod_q)) +
						66'(C1 * (64'(ready_q) + (idle_q ? 64'sd0 : 64'sd1))));
					dcnt_q <= DCW'(DIVN + 1);
				end
				bsd_pkg::ST_DIV: if (dcnt_q != '0) dcnt_q <= dcnt_q - 1'b1;
				bsd_pkg::ST_SWEEP_WR: idx_q <= idx_q + 1'b1;
				default: ;
			endcase
		end
	end

	// payload and datapath registers
	logic signed [33:0] twice_w, sum_w;
	assign twice_w = 34'(la_q) * 2;
	assign sum_w = twice_w + 34'(ONE);
	logic [64:0] trial;
	assign trial = {drem_q, dnum_q[63]} - 65'(dden_q);
	always_ff @(posedge clk) begin
		case (state_q)
			bsd_pkg::ST_IDLE: if (in_valid) begin
				cmd_q <= cmd;
				tid_q <= thread_id;
				nice_q <= nice_in[5:0];
				ipri_q <= initial_priority;
				idle_q <= running_is_idle;
				ready_q <= ready_threads;
			end
			bsd_pkg::ST_LA_MUL: prod_q <= 64'(la_q) * C59;
			bsd_pkg::ST_LA_ADD: ;
			bsd_pkg::ST_DIV: begin
				if (dcnt_q == DCW'(DIVN + 1)) begin
					// numerator is twice*ONE, nonnegative when sum > 0; its
					// DIVN significant bits sit at the top of the shifter
					dnum_q <= 64'(twice_w) << (FRACTION_BITS + 64 - DIVN);
					dden_q <= 33'(sum_w);
					drem_q <= '0;
					coeff_q <= '0;
				end else if (dcnt_q != '0) begin
					if (!trial[64]) begin
						drem_q <= trial[63:0];
						coeff_q <= {coeff_q[30:0], 1'b1};
					end else begin
						drem_q <= {drem_q[62:0], dnum_q[63]};
						coeff_q <= {coeff_q[30:0], 1'b0};
					end
					dnum_q <= {dnum_q[62:0], 1'b0};
				end
				if (dcnt_q == '0 && sum_w <= 0) coeff_q <= '0;
			end
			bsd_pkg::ST_SWEEP_MUL: prod_q <= 64'(rd_rc) * 64'(coeff_q);
			bsd_pkg::ST_OUT_MUL: begin
				opri_q <= pri_out;
				rc100_q <= 64'(rc_out) * 100;
				la100_q <= 64'(la_q) * 100;
			end
			bsd_pkg::ST_OUT_RND: begin
				orc_q <= bsd_pkg::sat32(66'(rdiv(rc100_q)));
				if (rdiv(la100_q) < 0) ola_q <= '0;
				else if (rdiv(la100_q) > 8191) ola_q <= 13'd8191;
				else ola_q <= 13'(rdiv(la100_q));
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
